### src/poi_pkg.sv
// Shared types and constants for the planar odometry integrator.
// No dependencies; ctrl, dpath, top and bench all import it.
package poi_pkg;

	localparam int unsigned ITER_W     = 5;
	localparam int unsigned DIV_CYCLES = 6;
	localparam int unsigned CNT_W      = 5;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
	localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
	localparam logic signed [32:0] CORDIC_K_Q30 = 33'sd652032874;
	localparam logic [20:0] MILLION    = 21'd1000000;
	localparam logic [30:0] RECIP_Q44  = 31'd1125899907;
	localparam logic [56:0] HALF_MILLION = 57'd500000;
	localparam logic signed [57:0] STEP_LIM = 58'sd2147483648;
	localparam logic signed [65:0] ROUND_Q30 = 66'sd536870912;

	typedef enum logic [16:0] {
		ST_IDLE   = 17'h00001,
		ST_DECODE = 17'h00002,
		ST_MULV   = 17'h00004,
		ST_DINIT  = 17'h00008,
		ST_DSTEP  = 17'h00010,
		ST_DEND   = 17'h00020,
		ST_HEAD   = 17'h00040,
		ST_CINIT  = 17'h00080,
		ST_CSTEP  = 17'h00100,
		ST_R0     = 17'h00200,
		ST_R1     = 17'h00400,
		ST_R2     = 17'h00800,
		ST_R3     = 17'h01000,
		ST_R4     = 17'h02000,
		ST_R5     = 17'h04000,
		ST_DONE   = 17'h08000,
		ST_WAIT   = 17'h10000
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_SET, OP_SKIP, OP_START, OP_MULV, OP_DINIT, OP_DSTEP,
		OP_DEND, OP_HEAD, OP_CINIT, OP_CSTEP, OP_R0, OP_R1, OP_R2, OP_R3, OP_R4,
		OP_R5, OP_OUT
	} op_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_W = 2'd2
	} axis_t;

	typedef struct packed {
		op_t              op;
		axis_t            axis;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic kind;
	} status_t;

	function automatic logic signed [27:0] atan_q24(input logic [ITER_W-1:0] i);
		logic signed [27:0] r;
		case (i)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778716;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
			input logic signed [65:0] acc);
		logic signed [65:0] s;
		s = 66'(p) + (acc >>> 30);
		if (s > 66'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (s < -66'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

endpackage

### src/poi_item_if.sv
// Input channel: velocity samples and set-position commands.
// No dependencies.
interface poi_item_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [47:0]        timestamp_us;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_y;
	logic signed [23:0] vel_omega;
	logic signed [31:0] set_x;
	logic signed [31:0] set_y;
	logic [18:0]        set_heading;

	modport source (output valid, kind, timestamp_us, vel_x, vel_y, vel_omega, set_x, set_y,
		set_heading, input ready);
	modport sink (input valid, kind, timestamp_us, vel_x, vel_y, vel_omega, set_x, set_y,
		set_heading, output ready);
endinterface

### src/poi_result_if.sv
// Result channel: pose and latest velocities.
// No dependencies.
interface poi_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [18:0]        heading;
	logic signed [23:0] cur_vel_x;
	logic signed [23:0] cur_vel_y;
	logic signed [23:0] cur_vel_omega;

	modport source (output valid, pos_x, pos_y, heading, cur_vel_x, cur_vel_y, cur_vel_omega,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, cur_vel_x, cur_vel_y, cur_vel_omega,
		output ready);
endinterface

### src/poi_ctrl.sv
// Sequencer: handshakes, skip counter, config register, step counters.
// Depends on poi_pkg.
module poi_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  poi_pkg::status_t status,
	output poi_pkg::cmd_t    cmd
);
	import poi_pkg::*;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_CYCLES - 1);
	localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);

	state_t            state_q, state_d;
	logic [7:0]        ignore_q, skipped_q;
	logic [CNT_W-1:0]  cnt_q;
	axis_t             axis_q;
	logic              out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.axis = axis_q;
		cmd.iter = cnt_q[ITER_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.kind) begin
					cmd.op  = OP_SET;
					state_d = ST_DONE;
				end else if (skipped_q < ignore_q) begin
					cmd.op  = OP_SKIP;
					state_d = ST_DONE;
				end else begin
					cmd.op  = OP_START;
					state_d = ST_MULV;
				end
			end
			ST_MULV: begin
				cmd.op  = OP_MULV;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.op  = OP_DINIT;
				state_d = ST_DSTEP;
			end
			ST_DSTEP: begin
				cmd.op = OP_DSTEP;
				if (cnt_q == DIV_LAST)
					state_d = ST_DEND;
			end
			ST_DEND: begin
				cmd.op  = OP_DEND;
				state_d = (axis_q == AX_W) ? ST_HEAD : ST_MULV;
			end
			ST_HEAD: begin
				cmd.op  = OP_HEAD;
				state_d = ST_CINIT;
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				state_d = ST_CSTEP;
			end
			ST_CSTEP: begin
				cmd.op = OP_CSTEP;
				if (cnt_q == CORD_LAST)
					state_d = ST_R0;
			end
			ST_R0: begin
				cmd.op  = OP_R0;
				state_d = ST_R1;
			end
			ST_R1: begin
				cmd.op  = OP_R1;
				state_d = ST_R2;
			end
			ST_R2: begin
				cmd.op  = OP_R2;
				state_d = ST_R3;
			end
			ST_R3: begin
				cmd.op  = OP_R3;
				state_d = ST_R4;
			end
			ST_R4: begin
				cmd.op  = OP_R4;
				state_d = ST_R5;
			end
			ST_R5: begin
				cmd.op  = OP_R5;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_ready) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ignore_q    <= '0;
			skipped_q   <= '0;
			cnt_q       <= '0;
			axis_q      <= AX_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				ignore_q <= cfg_wr_data;
			if (cmd.op == OP_SKIP)
				skipped_q <= skipped_q + 8'd1;
			if (cmd.op == OP_START)
				axis_q <= AX_X;
			else if (cmd.op == OP_DEND && axis_q == AX_X)
				axis_q <= AX_Y;
			else if (cmd.op == OP_DEND && axis_q == AX_Y)
				axis_q <= AX_W;
			if (cmd.op == OP_DSTEP || cmd.op == OP_CSTEP)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

### src/poi_dpath.sv
// Datapath: pose state, shared multiplier, divide by one million in 16-bit
// digits by reciprocal multiplication, iterative CORDIC and the result register.
// Depends on poi_pkg.
module poi_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  poi_pkg::cmd_t      cmd,
	output poi_pkg::status_t   status,
	input  logic               in_kind,
	input  logic [47:0]        in_ts,
	input  logic signed [23:0] in_vx,
	input  logic signed [23:0] in_vy,
	input  logic signed [23:0] in_vw,
	input  logic signed [31:0] in_set_x,
	input  logic signed [31:0] in_set_y,
	input  logic [18:0]        in_set_h,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic [18:0]        out_h,
	output logic signed [23:0] out_vx,
	output logic signed [23:0] out_vy,
	output logic signed [23:0] out_vw
);
	import poi_pkg::*;

	logic               kind_q;
	logic [47:0]        ts_q, last_time_q;
	logic signed [23:0] vin_q [3];
	logic signed [23:0] vel_q [3];
	logic signed [31:0] setx_q, sety_q, x_q, y_q;
	logic [18:0]        seth_q, hd_q;
	logic [31:0]        dt_q;
	logic signed [65:0] prod_q, acc_q;
	logic [56:0]        mag_q, quo_q;
	logic               neg_q, fold_q;
	logic [19:0]        rem_q;
	logic signed [32:0] dx_q, dy_q, cx_q, cy_q;
	logic signed [57:0] dw_q;
	logic signed [27:0] ang_q;

	logic [47:0]        dtu;
	logic [31:0]        dt_sat;
	logic signed [32:0] mul_a, mul_b, cos_v, sin_v, xs, ys;
	logic signed [65:0] abs_p;
	logic [35:0]        div_num;
	logic [15:0]        div_digit;
	logic signed [57:0] qval;
	logic signed [32:0] qclamp;
	logic signed [58:0] hsum;
	logic [18:0]        hclamp;
	logic signed [27:0] a0, a1, a2, atan_v;
	logic               fold_d;

	assign status.kind = kind_q;

	assign dtu    = ts_q - last_time_q;
	assign dt_sat = (|dtu[47:32]) ? '1 : dtu[31:0];
	assign cos_v  = fold_q ? -cx_q : cx_q;
	assign sin_v  = fold_q ? -cy_q : cy_q;

	// digit 0 is the top 25 bits, then two 16-bit digits below the remainder
	always_comb begin
		case (cmd.iter[2:1])
			2'd0:    div_num = {11'd0, mag_q[56:32]};
			2'd1:    div_num = {rem_q, mag_q[31:16]};
			default: div_num = {rem_q, mag_q[15:0]};
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_MULV: begin
				mul_a = 33'(vin_q[cmd.axis]);
				mul_b = $signed({1'b0, dt_q});
			end
			OP_DSTEP: begin
				mul_a = $signed({3'd0, div_num[35:6]});
				mul_b = $signed({2'd0, RECIP_Q44});
			end
			OP_R0: begin
				mul_a = dx_q;
				mul_b = cos_v;
			end
			OP_R1: begin
				mul_a = dy_q;
				mul_b = sin_v;
			end
			OP_R2: begin
				mul_a = dx_q;
				mul_b = sin_v;
			end
			OP_R3: begin
				mul_a = dy_q;
				mul_b = cos_v;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign abs_p     = prod_q[65] ? -prod_q : prod_q;
	assign div_digit = prod_q[59:44];
	assign qval      = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		if (qval > STEP_LIM)
			qclamp = STEP_LIM[32:0];
		else if (qval < -STEP_LIM)
			qclamp = -STEP_LIM[32:0];
		else
			qclamp = qval[32:0];
	end

	assign hsum = $signed({40'd0, hd_q}) + 59'(dw_q);
	always_comb begin
		if (hsum < 0)
			hclamp = '0;
		else if (hsum > $signed({40'd0, TWO_PI_Q16}))
			hclamp = TWO_PI_Q16;
		else
			hclamp = hsum[18:0];
	end

	always_comb begin
		a0     = $signed({1'b0, hd_q, 8'd0});
		a1     = (a0 > PI_Q24) ? a0 - TWO_PI_Q24 : a0;
		fold_d = 1'b0;
		a2     = a1;
		if (a1 > HALF_PI_Q24) begin
			a2     = a1 - PI_Q24;
			fold_d = 1'b1;
		end else if (a1 < -HALF_PI_Q24) begin
			a2     = a1 + PI_Q24;
			fold_d = 1'b1;
		end
	end

	assign xs     = cx_q >>> cmd.iter;
	assign ys     = cy_q >>> cmd.iter;
	assign atan_v = atan_q24(cmd.iter);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q         <= '0;
			y_q         <= '0;
			hd_q        <= '0;
			last_time_q <= '0;
			vel_q[0]    <= '0;
			vel_q[1]    <= '0;
			vel_q[2]    <= '0;
		end else begin
			case (cmd.op)
				OP_SET: begin
					x_q  <= setx_q;
					y_q  <= sety_q;
					hd_q <= (seth_q > TWO_PI_Q16) ? TWO_PI_Q16 : seth_q;
				end
				OP_SKIP: last_time_q <= ts_q;
				OP_START: begin
					last_time_q <= ts_q;
					vel_q[0]    <= vin_q[0];
					vel_q[1]    <= vin_q[1];
					vel_q[2]    <= vin_q[2];
				end
				OP_HEAD: hd_q <= hclamp;
				OP_R3:   x_q  <= sat_add(x_q, acc_q);
				OP_R5:   y_q  <= sat_add(y_q, acc_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q   <= in_kind;
				ts_q     <= in_ts;
				vin_q[0] <= in_vx;
				vin_q[1] <= in_vy;
				vin_q[2] <= in_vw;
				setx_q   <= in_set_x;
				sety_q   <= in_set_y;
				seth_q   <= in_set_h;
			end
			OP_START: dt_q <= dt_sat;
			OP_MULV:  prod_q <= mul_a * mul_b;
			OP_DINIT: begin
				neg_q <= prod_q[65];
				mag_q <= abs_p[56:0] + HALF_MILLION;
				rem_q <= '0;
				quo_q <= '0;
			end
			OP_DSTEP: begin
				if (!cmd.iter[0]) begin
					prod_q <= mul_a * mul_b;
				end else begin
					rem_q <= 20'(div_num - 36'(div_digit) * 36'(MILLION));
					quo_q <= {quo_q[40:0], div_digit};
				end
			end
			OP_DEND: begin
				case (cmd.axis)
					AX_X:    dx_q <= qclamp;
					AX_Y:    dy_q <= qclamp;
					default: dw_q <= qval;
				endcase
			end
			OP_CINIT: begin
				ang_q  <= a2;
				fold_q <= fold_d;
				cx_q   <= CORDIC_K_Q30;
				cy_q   <= '0;
			end
			OP_CSTEP: begin
				if (ang_q >= 0) begin
					cx_q  <= cx_q - ys;
					cy_q  <= cy_q + xs;
					ang_q <= ang_q - atan_v;
				end else begin
					cx_q  <= cx_q + ys;
					cy_q  <= cy_q - xs;
					ang_q <= ang_q + atan_v;
				end
			end
			OP_R0: prod_q <= mul_a * mul_b;
			OP_R1: begin
				acc_q  <= prod_q + ROUND_Q30;
				prod_q <= mul_a * mul_b;
			end
			OP_R2: begin
				acc_q  <= acc_q - prod_q;
				prod_q <= mul_a * mul_b;
			end
			OP_R3: begin
				acc_q  <= prod_q + ROUND_Q30;
				prod_q <= mul_a * mul_b;
			end
			OP_R4: acc_q <= acc_q + prod_q;
			OP_OUT: begin
				out_x  <= x_q;
				out_y  <= y_q;
				out_h  <= hd_q;
				out_vx <= vel_q[0];
				out_vy <= vel_q[1];
				out_vw <= vel_q[2];
			end
			default: ;
		endcase
	end
endmodule

### src/planar_odometry_integrator.sv
// Top level of the planar odometry integrator.
// Depends on poi_pkg, poi_item_if, poi_result_if, poi_ctrl, poi_dpath.
//
// Every beat on item gives one beat on result. A set command or a skipped
// sample goes from decode straight to the output register; an integrating
// sample first runs the velocity multiply and the divide for each axis, then
// the heading update, the CORDIC steps and the rotation steps R0 to R5.
// The divide by one million is done once per axis as three 16-bit digits by
// reciprocal multiplication; the rotation uses the output of the
// single iterative CORDIC unit. One item is in work at a time; the next is
// taken once the result sits in the output register.
module planar_odometry_integrator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	poi_item_if.sink    item,
	poi_result_if.source result
);
	import poi_pkg::*;

	cmd_t    cmd;
	status_t status;

	poi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (item.valid),
		.in_ready   (item.ready),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	poi_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.in_kind (item.kind),
		.in_ts   (item.timestamp_us),
		.in_vx   (item.vel_x),
		.in_vy   (item.vel_y),
		.in_vw   (item.vel_omega),
		.in_set_x(item.set_x),
		.in_set_y(item.set_y),
		.in_set_h(item.set_heading),
		.out_x   (result.pos_x),
		.out_y   (result.pos_y),
		.out_h   (result.heading),
		.out_vx  (result.cur_vel_x),
		.out_vy  (result.cur_vel_y),
		.out_vw  (result.cur_vel_omega)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while busy");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.heading <= TWO_PI_Q16)
		else $error("heading out of range");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !$rose(result.valid))
		else $error("result too early");
endmodule

### verif/planar_odometry_integrator_test.sv
// Self-checking bench for planar_odometry_integrator: directed and random velocity
// samples and set commands under varied idling, with a built-in pose predictor.
// Depends on poi_pkg, poi_item_if, poi_result_if and the block's RTL.
module planar_odometry_integrator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import poi_pkg::*;

	localparam int N_STEPS = 16;
	localparam logic KIND_VEL = 1'b0;
	localparam logic KIND_SET = 1'b1;

	typedef struct {
		logic               kind;
		logic [47:0]        ts;
		logic signed [23:0] vx, vy, vw;
		logic signed [31:0] sx, sy;
		logic [18:0]        sh;
	} sample_t;

	typedef struct {
		logic signed [31:0] px, py;
		logic [18:0]        hdg;
		logic signed [23:0] vx, vy, vw;
	} pose_t;

	class pose_tracker;
		pose_t       expected_poses[$];
		logic [7:0]  ignore_cnt;
		logic [7:0]  skipped;
		logic [47:0] last_ts;
		pose_t       cur;
		int          errors;
		int          poses_seen;
		int          integrated;
		int          skips;
		int          sets;

		function new();
			ignore_cnt = 0;
			skipped = 0;
			last_ts = 0;
			cur = '{default: 0};
		endfunction

		function longint rdiv_million(longint p);
			if (p >= 0)
				return (p + 500000) / 1000000;
			return -((-p + 500000) / 1000000);
		endfunction

		function longint clampl(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void cos_sin(logic [18:0] h, output longint c, output longint s);
			longint a, x, y, xs, ys;
			bit     flip;
			a = longint'(h) << 8;
			flip = 0;
			x = longint'(CORDIC_K_Q30);
			y = 0;
			if (a > longint'(PI_Q24))
				a -= longint'(TWO_PI_Q24);
			if (a > longint'(HALF_PI_Q24)) begin
				a -= longint'(PI_Q24);
				flip = 1;
			end else if (a < -longint'(HALF_PI_Q24)) begin
				a += longint'(PI_Q24);
				flip = 1;
			end
			for (int i = 0; i < N_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (a >= 0) begin
					x = x - ys;
					y = y + xs;
					a -= longint'(atan_q24(i[4:0]));
				end else begin
					x = x + ys;
					y = y - xs;
					a += longint'(atan_q24(i[4:0]));
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void take_item(sample_t b);
			logic [47:0] dtu;
			longint dt, vx, vy, vw, dx, dy, dw, c, s, rx, ry;
			if (b.kind == KIND_SET) begin
				cur.px = b.sx;
				cur.py = b.sy;
				cur.hdg = b.sh > TWO_PI_Q16 ? TWO_PI_Q16 : b.sh;
				sets++;
			end else begin
				if (skipped < ignore_cnt) begin
					skipped++;
					skips++;
				end else begin
					dtu = b.ts - last_ts;
					dt = dtu > 48'hFFFF_FFFF ? 64'hFFFF_FFFF : longint'(dtu);
					vx = b.vx;
					vy = b.vy;
					vw = b.vw;
					cur.vx = b.vx;
					cur.vy = b.vy;
					cur.vw = b.vw;
					dx = clampl(rdiv_million(vx * dt), -64'sd2147483648, 64'sd2147483648);
					dy = clampl(rdiv_million(vy * dt), -64'sd2147483648, 64'sd2147483648);
					dw = rdiv_million(vw * dt);
					cur.hdg = 19'(clampl(longint'(cur.hdg) + dw, 0, longint'(TWO_PI_Q16)));
					cos_sin(cur.hdg, c, s);
					rx = (dx * c - dy * s + (64'sd1 << 29)) >>> 30;
					ry = (dx * s + dy * c + (64'sd1 << 29)) >>> 30;
					cur.px = 32'(clampl(longint'(cur.px) + rx, -64'sd2147483648, 64'sd2147483647));
					cur.py = 32'(clampl(longint'(cur.py) + ry, -64'sd2147483648, 64'sd2147483647));
					integrated++;
				end
				last_ts = b.ts;
			end
			expected_poses.push_back(cur);
		endfunction

		function void check_pose(pose_t got);
			pose_t e;
			poses_seen++;
			if (expected_poses.size() == 0) begin
				$error("result beat with no pending expectation");
				errors++;
				return;
			end
			e = expected_poses.pop_front();
			if (got.px !== e.px) begin
				$error("pos_x expected %0d got %0d", e.px, got.px); errors++;
			end
			if (got.py !== e.py) begin
				$error("pos_y expected %0d got %0d", e.py, got.py); errors++;
			end
			if (got.hdg !== e.hdg) begin
				$error("heading expected %0d got %0d", e.hdg, got.hdg); errors++;
			end
			if (got.vx !== e.vx) begin
				$error("cur_vel_x expected %0d got %0d", e.vx, got.vx); errors++;
			end
			if (got.vy !== e.vy) begin
				$error("cur_vel_y expected %0d got %0d", e.vy, got.vy); errors++;
			end
			if (got.vw !== e.vw) begin
				$error("cur_vel_omega expected %0d got %0d", e.vw, got.vw); errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	int         idle_pct;
	int         stall_pct;
	logic [47:0] clock_us;

	poi_item_if   item_ch();
	poi_result_if res_ch();
	pose_tracker  tracker;

	planar_odometry_integrator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item_ch),
		.result     (res_ch)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		pose_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.px = res_ch.pos_x;
			got.py = res_ch.pos_y;
			got.hdg = res_ch.heading;
			got.vx = res_ch.cur_vel_x;
			got.vy = res_ch.cur_vel_y;
			got.vw = res_ch.cur_vel_omega;
			tracker.check_pose(got);
		end
	end

	task automatic write_ignore(logic [7:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.ignore_cnt = v;
	endtask

	task automatic send_beat(sample_t b);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= b.kind;
		item_ch.timestamp_us <= b.ts;
		item_ch.vel_x <= b.vx;
		item_ch.vel_y <= b.vy;
		item_ch.vel_omega <= b.vw;
		item_ch.set_x <= b.sx;
		item_ch.set_y <= b.sy;
		item_ch.set_heading <= b.sh;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		tracker.take_item(b);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_poses.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_vel(logic [47:0] ts, logic signed [23:0] vx, logic signed [23:0] vy,
			logic signed [23:0] vw);
		sample_t b;
		b = '{kind: KIND_VEL, ts: ts, vx: vx, vy: vy, vw: vw,
			sx: $urandom, sy: $urandom, sh: 19'($urandom)};
		send_beat(b);
	endtask

	task automatic send_set(logic signed [31:0] x, logic signed [31:0] y, logic [18:0] h);
		sample_t b;
		b = '{kind: KIND_SET, ts: {16'($urandom), 32'($urandom)}, vx: 24'($urandom),
			vy: 24'($urandom), vw: 24'($urandom), sx: x, sy: y, sh: h};
		send_beat(b);
	endtask

	task automatic send_random();
		sample_t b;
		int      r;
		r = $urandom_range(99);
		if (r < 85) begin
			if ($urandom_range(99) < 12) begin
				send_set(32'($urandom_range(0, 2000000)) - 1000000,
					32'($urandom_range(0, 2000000)) - 1000000, 19'($urandom_range(0, 411775)));
			end else begin
				clock_us = clock_us + 48'($urandom_range(1, 200000));
				send_vel(clock_us, 24'(int'($urandom_range(0, 400000)) - 200000),
					24'(int'($urandom_range(0, 200000)) - 100000),
					24'(int'($urandom_range(0, 600000)) - 300000));
			end
		end else begin
			b.kind = 1'($urandom_range(1));
			b.ts = {16'($urandom), 32'($urandom)};
			b.vx = 24'($urandom);
			b.vy = 24'($urandom);
			b.vw = 24'($urandom);
			b.sx = $urandom;
			b.sy = $urandom;
			b.sh = 19'($urandom);
			if (b.kind == KIND_VEL)
				clock_us = b.ts;
			send_beat(b);
		end
	endtask

	initial begin
		#20ms;
		$display("planar_odometry_integrator verification failed");
		$finish;
	end

	initial begin
		int          idle_tab[4];
		int          stall_tab[4];
		logic [7:0]  ign_tab[4];
		tracker = new();
		idle_tab = '{0, 58, 0, 37};
		stall_tab = '{0, 0, 58, 37};
		ign_tab = '{8'd0, 8'd255, 8'd128, 8'd0};
		idle_pct = 0;
		stall_pct = 0;
		clock_us = 0;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		item_ch.valid = 0;
		item_ch.kind = 0;
		item_ch.timestamp_us = 0;
		item_ch.vel_x = 0;
		item_ch.vel_y = 0;
		item_ch.vel_omega = 0;
		item_ch.set_x = 0;
		item_ch.set_y = 0;
		item_ch.set_heading = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// skipped samples, first accepted sample, saturation and clamps
		write_ignore(8'd3);
		send_vel(48'd100, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
		send_vel(48'd200, 24'sd1, -24'sd1, 24'sd0);
		send_vel(48'd300, 24'sd0, 24'sd0, 24'sd0);
		send_vel(48'd1000000, 24'sh7FFFFF, 24'sh800000, 24'sd65536);
		send_set(32'sh7FFFFFFF, 32'sh80000000, 19'h7FFFF);
		send_vel(48'd1000005 + 48'h1_0000_0000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		send_vel(48'd500, 24'sh800000, 24'sh800000, 24'sh800000);
		send_set(32'sd0, 32'sd0, 19'd0);
		send_vel(48'd1500, -24'sd1000, 24'sd1000, 24'sd500);
		send_set(32'sd0, 32'sd0, TWO_PI_Q16);
		send_vel(48'd2500, 24'sd65536, 24'sd0, 24'sd0);
		send_set(32'sd100, -32'sd100, 19'd102944);
		send_vel(48'd502500, 24'sd65536, 24'sd32768, 24'sd0);
		drain();
		send_set(32'sd0, 32'sd0, 19'd205887);
		send_vel(48'd1002500, 24'sd65536, -24'sd32768, 24'sd0);
		send_set(-32'sd5, 32'sd5, 19'd308831);
		send_vel(48'd1502500, -24'sd65536, 24'sd65536, 24'sd0);
		send_vel(48'hFFFF_FFFF_FFFF, 24'sd1, 24'sd1, 24'sd1);
		send_vel(48'd3, 24'sd2, -24'sd2, -24'sd2);
		send_set(32'sd1, 32'sd2, 19'd411776);
		send_vel(48'd999, 24'sd500, 24'sd500, 24'sd500);
		clock_us = 48'd999;

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_ignore(ign_tab[ph]);
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			for (int n = 0; n < 110; n++)
				send_random();
		end
		drain();
		idle_pct = 0;
		stall_pct = 0;
		repeat (20) @(posedge clk);

		$display("Checked %0d result beats: %0d integrating samples, %0d skipped, %0d set commands",
			tracker.poses_seen, tracker.integrated, tracker.skips, tracker.sets);
		$display("Ignore counts 0, 3, 128 and 255 under four idle/stall mixes");
		if (tracker.errors == 0 && tracker.expected_poses.size() == 0)
			$display("planar_odometry_integrator verification clean");
		else
			$display("planar_odometry_integrator verification failed");
		$finish;
	end
endmodule
